// File: rtl/core/bcma_pkg.sv
// Shared types and constants for the banked core memory unit.
// No dependencies; imported by banked_core_memory_access.
`default_nettype none

package bcma_pkg;

    // Store sizes and the address widths that follow from them
    localparam int ERASABLE_WORDS = 2048;
    localparam int FIXED_WORDS    = 65536;
    localparam int ER_AW          = $clog2(ERASABLE_WORDS);
    localparam int FX_AW          = $clog2(FIXED_WORDS);

    // Access modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // Erasable address that trips the night-watchman
    localparam logic [ER_AW-1:0] WATCHMAN_ADDR = ER_AW'(11'o67);

    // What the second stage must do with the memory read data
    typedef struct packed {
        logic erasable;
        logic fixed;
        logic watch;
    } bcma_sel_t;

    // Write-back word: bit 14 takes the value of bit 15
    function automatic logic [15:0] wb_word(input logic [15:0] g);
        wb_word = {g[15], g[15], g[13:0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bcma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old word.
`default_nettype none

module bcma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/banked_core_memory_access.sv
// Banked core memory unit: erasable and fixed stores with bank switching.
// Depends on bcma_pkg and bcma_ram.
//
// Usage:
//   Request channel (req_valid / req_ready) carries one access: a read of
//   the S address, a write-back of G to the erasable word last read, or a
//   load of one fixed word with its parity flag.
//   Response channel (rsp_valid / rsp_ready) returns one result for every
//   request: read data, parity alarm and night-watchman flag.
//   Path: an accepted request is registered in the read stage and its result
//   in the output register before the response is offered.
//   Throughput: one request per cycle outside the clear pass and stalls; the
//   memory read port of each store is used at most once per request and its
//   registered read data forms the second stage.
//   Reset: the erasable store is cleared by a pass over all 2048 words, one
//   word per cycle; req_ready stays low until the pass is done. Fixed memory is
//   not cleared and must be loaded before it is read.
//   Stall: when rsp_ready is low the response holds; one more request can
//   sit in the read stage, after which req_ready drops.
`default_nettype none

module banked_core_memory_access
    import bcma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [11:0] s_addr,
    input  wire logic [2:0]  erasable_bank,
    input  wire logic [4:0]  fixed_bank,
    input  wire logic [2:0]  fixed_extension,
    input  wire logic [15:0] write_data,
    input  wire logic [15:0] load_address,
    input  wire logic [15:0] load_word,
    input  wire logic        load_parity_ok,
    // response channel
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [15:0]      read_data,
    output logic             parity_alarm,
    output logic             watchman_reset
);

    // Control state
    logic             clr_active_reg;
    logic [ER_AW-1:0] clr_cnt_reg;
    logic             pend_valid_reg;
    logic [ER_AW-1:0] pend_addr_reg;
    logic             s1_valid_reg;
    bcma_sel_t        s1_sel_reg;
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;
    logic             out_alarm_reg;
    logic             out_watch_reg;

    // Decode and handshake signals
    logic             req_xfer;
    logic             s1_move;
    logic             is_read;
    logic             rd_special;
    logic             rd_erasable;
    logic             rd_fixed;
    logic [ER_AW-1:0] er_addr;
    logic [15:0]      fx_full;
    logic [FX_AW-1:0] fx_addr;
    logic [FX_AW-1:0] ld_addr;
    bcma_sel_t        sel_next;

    // Memory ports
    logic             er_we;
    logic [ER_AW-1:0] er_waddr;
    logic [15:0]      er_wdata;
    logic [15:0]      er_rdata;
    logic             fx_we;
    logic [16:0]      fx_rdata;

    // Handshake: read stage advances when the output register is free or its response is taken
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !clr_active_reg && (!s1_valid_reg || s1_move);
    assign req_xfer  = req_valid && req_ready;

    // Address decode of S
    always_comb
    begin
        is_read     = (mode == MODE_READ);
        rd_special  = (s_addr[11:3] == 9'd0);
        rd_erasable = is_read && !rd_special && (s_addr[11:10] == 2'b00);
        rd_fixed    = is_read && s_addr[11];
        rd_fixed    = rd_fixed || (is_read && (s_addr[11:10] == 2'b01));

        // switched erasable at and above octal 1400
        if (s_addr[9:8] == 2'b11)
        begin
            er_addr = {erasable_bank, s_addr[7:0]};
        end
        else
        begin
            er_addr = ER_AW'(s_addr[9:0]);
        end

        // fixed-fixed, superbank or plain switched fixed
        if (s_addr[11])
        begin
            fx_full = {4'd0, s_addr};
        end
        else if ((fixed_bank[4:3] == 2'b11) && fixed_extension[2])
        begin
            fx_full = {fixed_extension, fixed_bank[2:0], s_addr[9:0]};
        end
        else
        begin
            fx_full = {1'b0, fixed_bank, s_addr[9:0]};
        end
        fx_addr = fx_full[FX_AW-1:0];
        ld_addr = load_address[FX_AW-1:0];

        sel_next.erasable = rd_erasable;
        sel_next.fixed    = rd_fixed;
        sel_next.watch    = rd_erasable && (er_addr == WATCHMAN_ADDR);
    end

    // Erasable write port: clear pass, destructive read, or write-back
    always_comb
    begin
        er_we    = 1'b0;
        er_waddr = pend_addr_reg;
        er_wdata = 16'd0;
        if (clr_active_reg)
        begin
            er_we    = 1'b1;
            er_waddr = clr_cnt_reg;
        end
        else if (req_xfer && rd_erasable)
        begin
            er_we    = 1'b1;
            er_waddr = er_addr;
        end
        else if (req_xfer && (mode == MODE_WRITE) && pend_valid_reg)
        begin
            er_we    = 1'b1;
            er_wdata = wb_word(write_data);
        end
    end

    assign fx_we = req_xfer && (mode == MODE_LOAD);

    bcma_ram #(
        .WIDTH (16),
        .DEPTH (ERASABLE_WORDS)
    ) u_erasable (
        .clk   (clk),
        .we    (er_we),
        .waddr (er_waddr),
        .wdata (er_wdata),
        .re    (req_xfer && rd_erasable),
        .raddr (er_addr),
        .rdata (er_rdata)
    );

    // Fixed store: parity flag on top of the word
    bcma_ram #(
        .WIDTH (17),
        .DEPTH (FIXED_WORDS)
    ) u_fixed (
        .clk   (clk),
        .we    (fx_we),
        .waddr (ld_addr),
        .wdata ({load_parity_ok, load_word}),
        .re    (req_xfer && rd_fixed),
        .raddr (fx_addr),
        .rdata (fx_rdata)
    );

    // Clear pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Pending write-back address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
        end
        else if (req_xfer && rd_erasable)
        begin
            pend_valid_reg <= 1'b1;
            pend_addr_reg  <= er_addr;
        end
        else if (req_xfer && (mode == MODE_WRITE))
        begin
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
        end
    end

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_sel_reg   <= '0;
        end
        else if (req_xfer)
        begin
            s1_valid_reg <= 1'b1;
            s1_sel_reg   <= sel_next;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            if (s1_sel_reg.erasable)
            begin
                out_data_reg <= er_rdata;
            end
            else if (s1_sel_reg.fixed)
            begin
                out_data_reg <= fx_rdata[15:0];
            end
            else
            begin
                out_data_reg <= 16'd0;
            end
            out_alarm_reg <= s1_sel_reg.fixed && !fx_rdata[16];
            out_watch_reg <= s1_sel_reg.watch;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign read_data      = out_data_reg;
    assign parity_alarm   = out_alarm_reg;
    assign watchman_reset = out_watch_reg;

endmodule

`default_nettype wire

// File: rtl/core/bcma_checker.sv
// Port-level checks for the banked core memory unit, bound to the top level.
// Depends on banked_core_memory_access.
`default_nettype none

module bcma_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        parity_alarm,
    input wire logic        watchman_reset
);

    // A response stays offered until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    // A result is never both a fixed read and an erasable read
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(parity_alarm && watchman_reset))
        else $error("parity alarm and watchman flag together");

    // Clear pass blocks requests right after reset
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !req_ready)
        else $error("request taken during erasable clear");

    // No response can exist straight out of reset
    a_no_rsp_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

endmodule

bind banked_core_memory_access bcma_checker u_bcma_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req_ready),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .parity_alarm   (parity_alarm),
    .watchman_reset (watchman_reset)
);

`default_nettype wire
